// ===== sv/tpbp_pkg.sv =====
// Shared types and constants for the two-pattern block puncturer.
package tpbp_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned PosW     = 16;
  localparam int unsigned TailW    = 8;
  localparam int unsigned PatMax   = 64;
  localparam int unsigned PatIdxW  = $clog2(PatMax);
  localparam int unsigned PatLenW  = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegBlockLength   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTailCount     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNormalPattern = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNormalLength  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTailPattern   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTailLength    = 3'd5;

  typedef struct packed {
    logic [PosW-1:0]    block_length;
    logic [TailW-1:0]   tail_count;
    logic [PatMax-1:0]  normal_pattern;
    logic [PatLenW-1:0] normal_length;
    logic [PatMax-1:0]  tail_pattern;
    logic [PatLenW-1:0] tail_length;
  } cfg_t;

  typedef struct packed {
    logic            emit;
    logic [SymW-1:0] out_symbol;
    logic            kept;
    logic            block_end;
  } res_t;

  function automatic logic [PatLenW-1:0] eff_pat_len(input logic [PatLenW-1:0] len);
    logic [PatLenW-1:0] r;
    r = len;
    if (len == '0) r = PatLenW'(1);
    else if (len > PatLenW'(PatMax)) r = PatLenW'(PatMax);
    return r;
  endfunction

  function automatic logic [PatIdxW-1:0] next_idx(input logic [PatIdxW-1:0] idx,
                                                   input logic [PatLenW-1:0] len);
    logic [PatLenW-1:0] inc;
    inc = {{(PatLenW-PatIdxW){1'b0}}, idx} + PatLenW'(1);
    return (inc >= len) ? '0 : inc[PatIdxW-1:0];
  endfunction

endpackage

// ===== sv/tpbp_cfg.sv =====
// Configuration register file of the two-pattern block puncturer.
module tpbp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tpbp_pkg::CfgDataW-1:0]  cfg_data_i,
  output tpbp_pkg::cfg_t                 cfg_o
);
  import tpbp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBlockLength:   cfg_d.block_length   = cfg_data_i[PosW-1:0];
        RegTailCount:     cfg_d.tail_count     = cfg_data_i[TailW-1:0];
        RegNormalPattern: cfg_d.normal_pattern = cfg_data_i[PatMax-1:0];
        RegNormalLength:  cfg_d.normal_length  = cfg_data_i[PatLenW-1:0];
        RegTailPattern:   cfg_d.tail_pattern   = cfg_data_i[PatMax-1:0];
        RegTailLength:    cfg_d.tail_length    = cfg_data_i[PatLenW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_length   <= PosW'(1);
      cfg_q.tail_count     <= '0;
      cfg_q.normal_pattern <= '0;
      cfg_q.normal_length  <= PatLenW'(1);
      cfg_q.tail_pattern   <= '0;
      cfg_q.tail_length    <= PatLenW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/tpbp_sched.sv =====
// Block position and pattern index counters with the keep decision.
module tpbp_sched (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpbp_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [tpbp_pkg::SymW-1:0]   symbol_i,
  output tpbp_pkg::res_t              res_o
);
  import tpbp_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [PatIdxW-1:0] nidx_q, nidx_d;
  logic [PatIdxW-1:0] tidx_q, tidx_d;

  logic [PosW-1:0]    blen;
  logic [PatLenW-1:0] nlen, tlen;
  logic [PosW:0]      pos_tail, pos_inc;
  logic               normal, keep, last;

  always_comb begin
    blen     = (cfg_i.block_length == '0) ? PosW'(1) : cfg_i.block_length;
    nlen     = eff_pat_len(cfg_i.normal_length);
    tlen     = eff_pat_len(cfg_i.tail_length);
    pos_tail = {1'b0, pos_q} + {{(PosW+1-TailW){1'b0}}, cfg_i.tail_count};
    pos_inc  = {1'b0, pos_q} + (PosW+1)'(1);
    normal   = pos_tail <= {1'b0, blen};
    keep     = normal ? cfg_i.normal_pattern[nidx_q] : cfg_i.tail_pattern[tidx_q];
    last     = pos_inc >= {1'b0, blen};

    pos_d  = pos_q;
    nidx_d = nidx_q;
    tidx_d = tidx_q;
    if (step_i) begin
      if (last) begin
        pos_d  = '0;
        nidx_d = '0;
        tidx_d = '0;
      end else begin
        pos_d  = pos_inc[PosW-1:0];
        nidx_d = next_idx(nidx_q, nlen);
        tidx_d = next_idx(tidx_q, tlen);
      end
    end

    res_o.emit       = keep || last;
    res_o.out_symbol = keep ? symbol_i : '0;
    res_o.kept       = keep;
    res_o.block_end  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nidx_q <= '0;
      tidx_q <= '0;
    end else begin
      pos_q  <= pos_d;
      nidx_q <= nidx_d;
      tidx_q <= tidx_d;
    end
  end

endmodule

// ===== sv/tpbp_out_reg.sv =====
// Output result register with valid/ready handshake.
module tpbp_out_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  tpbp_pkg::res_t              res_i,
  input  logic                        out_ready_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  output logic [tpbp_pkg::SymW-1:0]   out_symbol_o,
  output logic                        kept_o,
  output logic                        block_end_o
);
  import tpbp_pkg::*;

  logic            valid_q, valid_d;
  logic [SymW-1:0] sym_q;
  logic            kept_q, end_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = res_i.emit;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sym_q  <= res_i.out_symbol;
      kept_q <= res_i.kept;
      end_q  <= res_i.block_end;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_symbol_o = sym_q;
  assign kept_o       = kept_q;
  assign block_end_o  = end_q;

endmodule

// ===== sv/two_pattern_block_puncturer.sv =====
// Top level of the two-pattern block puncturer.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o  | symbol_i
//   output   | out_valid_o / out_ready_i| out_symbol_o, kept_o, block_end_o
//   config   | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while in_ready_o is high; an emitted result appears in the cycle after its input.
// The counters and the 64-entry pattern select sit between the counter
// registers and the single output register.
// Reset clears the counters and output valid and loads the register defaults.
// A stalled output holds in_ready_o low until the result is taken.
module two_pattern_block_puncturer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tpbp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tpbp_pkg::SymW-1:0]      symbol_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tpbp_pkg::SymW-1:0]      out_symbol_o,
  output logic                           kept_o,
  output logic                           block_end_o
);
  import tpbp_pkg::*;

  cfg_t cfg;
  res_t res;
  logic accept;

  assign accept = in_valid_i && in_ready_o;

  tpbp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tpbp_sched u_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (accept),
    .symbol_i (symbol_i),
    .res_o    (res)
  );

  tpbp_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (res),
    .out_ready_i  (out_ready_i),
    .free_o       (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_symbol_o (out_symbol_o),
    .kept_o       (kept_o),
    .block_end_o  (block_end_o)
  );

`ifndef NO_ASSERTIONS
  a_bare_marker_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> block_end_o)
    else $error("bare marker without block end");

  a_dropped_symbol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> out_symbol_o == '0)
    else $error("dropped transaction carries nonzero symbol");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_emit_next_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.emit |=> out_valid_o)
    else $error("emitting transaction lost");
`endif

endmodule
